FILE: rtl/imu_scl_pkg.sv
// shared types and constants for the imu sample scaler
package imu_scl_pkg;

  localparam int RAW_W     = 16;
  localparam int AXIS_W    = 32;
  localparam int TEMP_W    = 25;
  localparam int CNT_W     = 8;
  localparam int GAIN_W    = 32;
  localparam int TGAIN_W   = 24;
  localparam int OFS_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int AXIS_SH   = 16;
  localparam int TEMP_SH   = 24;
  localparam int MEAN_SH   = 8;
  localparam int NUM_AXES  = 6;

  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;
  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7fff;

  localparam logic [GAIN_W-1:0]        ACCEL_GAIN_RST = 32'd2570754;
  localparam logic [GAIN_W-1:0]        GYRO_GAIN_RST  = 32'd32768000;
  localparam logic [TGAIN_W-1:0]       TEMP_GAIN_RST  = 24'd51337;
  localparam logic signed [OFS_W-1:0]  TEMP_OFS_RST   = 16'sd6400;

  typedef enum logic [2:0] {
    MUL_AX, MUL_AY, MUL_AZ, MUL_GX, MUL_GY, MUL_GZ, MUL_TEMP
  } mul_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_GAIN, REG_GYRO_GAIN, REG_TEMP_GAIN, REG_TEMP_OFS
  } cfg_reg_t;

  typedef struct packed {
    logic    capture;
    logic    accum;
    logic    mul_go;
    mul_op_t mul_op;
    logic    div_load;
    logic    div_step;
    logic    temp_fin;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

FILE: rtl/imu_scl_ctrl.sv
// controller state machine for the imu sample scaler
module imu_scl_ctrl #(
  parameter int MAX_BURST = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  imu_scl_pkg::dp_stat_t stat,
  output imu_scl_pkg::dp_cmd_t  cmd
);

  localparam int TALW = $clog2(MAX_BURST + 1);
  localparam int ACCW = imu_scl_pkg::RAW_W + TALW;
  localparam int NUMW = ACCW + imu_scl_pkg::MEAN_SH;
  localparam int CW   = $clog2(NUMW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_AXES, S_DLOAD, S_DIV, S_TMUL, S_TFIN, S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd = '0;
    cmd.mul_op = imu_scl_pkg::MUL_AX;
    unique case (state)
      S_IDLE: cmd.capture = s_tvalid;
      S_AXES: begin
        cmd.accum = (cnt == '0);
        if (cnt < CW'(imu_scl_pkg::NUM_AXES)) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = imu_scl_pkg::mul_op_t'(cnt[2:0]);
        end
      end
      S_DLOAD: cmd.div_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_TMUL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = imu_scl_pkg::MUL_TEMP;
      end
      S_TFIN: cmd.temp_fin = 1'b1;
      S_DONE: cmd.load_out = !out_valid || m_tready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_AXES;
            cnt   <= '0;
          end
        end
        S_AXES: begin
          if (cnt == CW'(imu_scl_pkg::NUM_AXES)) begin
            cnt   <= '0;
            state <= stat.last ? S_DLOAD : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DLOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CW'(NUMW - 1)) begin
            state <= S_TMUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TMUL: state <= S_TFIN;
        S_TFIN: state <= S_DONE;
        S_DONE: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/imu_scl_dp.sv
// datapath: config registers, shared multiplier, temperature sum and divider
module imu_scl_dp #(
  parameter int MAX_BURST = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [imu_scl_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [imu_scl_pkg::GAIN_W-1:0]         cfg_data,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   accel_x_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   accel_y_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   accel_z_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   temp_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   gyro_x_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   gyro_y_raw,
  input  logic signed [imu_scl_pkg::RAW_W-1:0]   gyro_z_raw,
  input  logic                                   burst_end,
  input  imu_scl_pkg::dp_cmd_t                   cmd,
  output imu_scl_pkg::dp_stat_t                  stat,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  accel_x_out,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  accel_y_out,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  accel_z_out,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  gyro_x_out,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  gyro_y_out,
  output logic signed [imu_scl_pkg::AXIS_W-1:0]  gyro_z_out,
  output logic signed [imu_scl_pkg::TEMP_W-1:0]  temp_celsius,
  output logic [imu_scl_pkg::CNT_W-1:0]          burst_count,
  output logic                                   last_sample
);

  localparam int RW   = imu_scl_pkg::RAW_W;
  localparam int AW   = imu_scl_pkg::AXIS_W;
  localparam int TALW = $clog2(MAX_BURST + 1);
  localparam int ACCW = RW + TALW;
  localparam int NUMW = ACCW + imu_scl_pkg::MEAN_SH;
  localparam int MAW  = imu_scl_pkg::MUL_A_W;
  localparam int MBW  = imu_scl_pkg::MUL_B_W;
  localparam int PW   = imu_scl_pkg::PROD_W;
  localparam int TSW  = PW - imu_scl_pkg::TEMP_SH;

  // configuration
  logic [imu_scl_pkg::GAIN_W-1:0]        accel_gain;
  logic [imu_scl_pkg::GAIN_W-1:0]        gyro_gain;
  logic [imu_scl_pkg::TGAIN_W-1:0]       temp_gain;
  logic signed [imu_scl_pkg::OFS_W-1:0]  temp_ofs;

  // captured sample
  logic signed [RW-1:0] ax, ay, az, tr, gx, gy, gz;
  logic                 last_q;

  // temperature sum and divider
  logic signed [ACCW-1:0] accum;
  logic [TALW-1:0]        tally;
  logic [TALW-1:0]        divisor;
  logic [TALW:0]          rem;
  logic [NUMW-1:0]        quo;
  logic                   neg;
  logic                   dzero;

  // shared multiplier
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [PW-1:0]   prod;
  imu_scl_pkg::mul_op_t   op_q;
  logic                   op_vld;

  // staged results
  logic signed [AW-1:0]                  res_ax, res_ay, res_az, res_gx, res_gy, res_gz;
  logic signed [imu_scl_pkg::TEMP_W-1:0] res_temp;
  logic [imu_scl_pkg::CNT_W-1:0]         res_cnt;

  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        mag;
  logic [TALW:0]          rem_sh;
  logic [TALW+1:0]        diff;
  logic                   ge;
  logic signed [MAW-1:0]  q_mean;
  logic signed [MAW-1:0]  mean;
  logic signed [TSW-1:0]  cel;

  function automatic logic signed [RW-1:0] neg_sat(input logic signed [RW-1:0] v);
    neg_sat = (v == imu_scl_pkg::RAW_MIN) ? imu_scl_pkg::RAW_MAX : -v;
  endfunction

  assign stat.last = last_q;

  always_comb begin
    num    = {accum, {imu_scl_pkg::MEAN_SH{1'b0}}};
    mag    = accum[ACCW-1] ? NUMW'(-num) : NUMW'(num);
    rem_sh = {rem[TALW-1:0], quo[NUMW-1]};
    diff   = {1'b0, rem_sh} - {2'b0, divisor};
    ge     = !diff[TALW+1];
    q_mean = quo[MAW-1:0];
    if (dzero) begin
      mean = '0;
    end else begin
      mean = neg ? -q_mean : q_mean;
    end
    cel = $signed(prod[PW-1:imu_scl_pkg::TEMP_SH]) + TSW'(temp_ofs);
  end

  always_comb begin
    unique case (cmd.mul_op)
      imu_scl_pkg::MUL_AX: begin
        mul_a = MAW'(ax);
        mul_b = {1'b0, accel_gain};
      end
      imu_scl_pkg::MUL_AY: begin
        mul_a = MAW'(neg_sat(ay));
        mul_b = {1'b0, accel_gain};
      end
      imu_scl_pkg::MUL_AZ: begin
        mul_a = MAW'(neg_sat(az));
        mul_b = {1'b0, accel_gain};
      end
      imu_scl_pkg::MUL_GX: begin
        mul_a = MAW'(gx);
        mul_b = {1'b0, gyro_gain};
      end
      imu_scl_pkg::MUL_GY: begin
        mul_a = MAW'(neg_sat(gy));
        mul_b = {1'b0, gyro_gain};
      end
      imu_scl_pkg::MUL_GZ: begin
        mul_a = MAW'(neg_sat(gz));
        mul_b = {1'b0, gyro_gain};
      end
      imu_scl_pkg::MUL_TEMP: begin
        mul_a = mean;
        mul_b = MBW'(temp_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= imu_scl_pkg::ACCEL_GAIN_RST;
      gyro_gain  <= imu_scl_pkg::GYRO_GAIN_RST;
      temp_gain  <= imu_scl_pkg::TEMP_GAIN_RST;
      temp_ofs   <= imu_scl_pkg::TEMP_OFS_RST;
    end else if (cfg_we) begin
      unique case (imu_scl_pkg::cfg_reg_t'(cfg_idx))
        imu_scl_pkg::REG_ACCEL_GAIN: accel_gain <= cfg_data;
        imu_scl_pkg::REG_GYRO_GAIN:  gyro_gain  <= cfg_data;
        imu_scl_pkg::REG_TEMP_GAIN:  temp_gain  <= cfg_data[imu_scl_pkg::TGAIN_W-1:0];
        imu_scl_pkg::REG_TEMP_OFS:   temp_ofs   <= $signed(cfg_data[imu_scl_pkg::OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // temperature sum, tally and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      tally <= '0;
    end else if (cmd.accum) begin
      if (tally < TALW'(MAX_BURST)) begin
        accum <= accum + ACCW'(tr);
        tally <= tally + 1'b1;
      end
    end else if (cmd.div_load) begin
      accum <= '0;
      tally <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo     <= mag;
      rem     <= '0;
      divisor <= tally;
      neg     <= accum[ACCW-1];
      dzero   <= (tally == '0);
    end else if (cmd.div_step) begin
      rem <= ge ? diff[TALW:0] : rem_sh;
      quo <= {quo[NUMW-2:0], ge};
    end
  end

  // multiplier stage with the operation tag that follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
    end else begin
      op_vld <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= mul_a * mul_b;
      op_q <= cmd.mul_op;
    end
  end

  // sample capture and result staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax       <= accel_x_raw;
      ay       <= accel_y_raw;
      az       <= accel_z_raw;
      tr       <= temp_raw;
      gx       <= gyro_x_raw;
      gy       <= gyro_y_raw;
      gz       <= gyro_z_raw;
      last_q   <= burst_end;
      res_temp <= '0;
      res_cnt  <= '0;
    end else begin
      if (cmd.div_load) begin
        res_cnt <= imu_scl_pkg::CNT_W'(tally);
      end
      if (cmd.temp_fin) begin
        res_temp <= cel[imu_scl_pkg::TEMP_W-1:0];
      end
    end
    if (op_vld) begin
      unique case (op_q)
        imu_scl_pkg::MUL_AX: res_ax <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        imu_scl_pkg::MUL_AY: res_ay <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        imu_scl_pkg::MUL_AZ: res_az <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        imu_scl_pkg::MUL_GX: res_gx <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        imu_scl_pkg::MUL_GY: res_gy <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        imu_scl_pkg::MUL_GZ: res_gz <= prod[AW+imu_scl_pkg::AXIS_SH-1:imu_scl_pkg::AXIS_SH];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accel_x_out  <= res_ax;
      accel_y_out  <= res_ay;
      accel_z_out  <= res_az;
      gyro_x_out   <= res_gx;
      gyro_y_out   <= res_gy;
      gyro_z_out   <= res_gz;
      temp_celsius <= res_temp;
      burst_count  <= res_cnt;
      last_sample  <= last_q;
    end
  end

endmodule

FILE: rtl/imu_fifo_sample_scaler_top.sv
// top level of the imu fifo sample scaler: stream ports, controller and datapath
// sequence: a mid-burst sample is captured and its six axes go through the multiplier;
//   a burst-end sample then adds the restoring divider, one quotient bit per cycle over
//   NUMW = 24 + clog2(MAX_BURST + 1) bits, and the temperature multiply before hand-off
// flow: a new sample is taken only after the last result is loaded; one shared multiplier,
//   and a stalled result waits in the output register while the next sample is worked
// reset: synchronous, active high; gains, offset, temperature sum and tally return to defaults
module imu_fifo_sample_scaler_top #(
  parameter int MAX_BURST = 128
) (
  input  logic          clk,
  input  logic          rst,
  // configuration write port
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_data,
  // input sample stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, temp_raw, gyro_x_raw, gyro_y_raw,
  // gyro_z_raw, 16 bits each
  input  logic [111:0]  s_tdata,
  input  logic          s_tlast,   // burst_end
  // output result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out
  // (32 bits each), temp_celsius (25), burst_count (8), 7 zero pad bits
  output logic [231:0]  m_tdata,
  output logic          m_tlast    // last_sample
);

  imu_scl_pkg::dp_cmd_t  cmd;
  imu_scl_pkg::dp_stat_t stat;

  logic signed [imu_scl_pkg::AXIS_W-1:0] accel_x_out, accel_y_out, accel_z_out;
  logic signed [imu_scl_pkg::AXIS_W-1:0] gyro_x_out, gyro_y_out, gyro_z_out;
  logic signed [imu_scl_pkg::TEMP_W-1:0] temp_celsius;
  logic [imu_scl_pkg::CNT_W-1:0]         burst_count;

  // sequencer: accept, six multiplies, optional divide and temperature scale, hand off
  imu_scl_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds config, sample, sum, divider, multiplier and the output register
  imu_scl_dp #(
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .accel_x_raw  ($signed(s_tdata[15:0])),
    .accel_y_raw  ($signed(s_tdata[31:16])),
    .accel_z_raw  ($signed(s_tdata[47:32])),
    .temp_raw     ($signed(s_tdata[63:48])),
    .gyro_x_raw   ($signed(s_tdata[79:64])),
    .gyro_y_raw   ($signed(s_tdata[95:80])),
    .gyro_z_raw   ($signed(s_tdata[111:96])),
    .burst_end    (s_tlast),
    .cmd          (cmd),
    .stat         (stat),
    .accel_x_out  (accel_x_out),
    .accel_y_out  (accel_y_out),
    .accel_z_out  (accel_z_out),
    .gyro_x_out   (gyro_x_out),
    .gyro_y_out   (gyro_y_out),
    .gyro_z_out   (gyro_z_out),
    .temp_celsius (temp_celsius),
    .burst_count  (burst_count),
    .last_sample  (m_tlast)
  );

  // pack the result fields, lowest field first
  assign m_tdata = {7'b0, burst_count, temp_celsius, gyro_z_out, gyro_y_out, gyro_x_out,
                    accel_z_out, accel_y_out, accel_x_out};

endmodule
